/* rtl/core/itra_pkg.sv */
// shared types, constants and the digit-to-character map for integer_to_radix_ascii
// used by itra_ctrl, itra_dp and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package itra_pkg;

	// default configuration
	localparam int DEF_VALUE_WIDTH = 32;
	localparam int DEF_MAX_DIGITS  = 32;

	// field widths
	localparam int RADIX_IN_W = 8;
	localparam int CHAR_W     = 8;
	localparam int RADIX_W    = 6;   // holds radix up to 36 and any digit value
	localparam int DIV_BITS   = 4;   // quotient bits per divider cycle

	// radix range and special radix
	localparam logic [RADIX_IN_W-1:0] RADIX_MIN = 8'd2;
	localparam logic [RADIX_IN_W-1:0] RADIX_MAX = 8'd36;
	localparam logic [RADIX_IN_W-1:0] DECIMAL   = 8'd10;

	// characters
	localparam logic [CHAR_W-1:0] MINUS_CHAR  = 8'h2D;
	localparam logic [CHAR_W-1:0] ZERO_CHAR   = 8'h30;
	localparam logic [CHAR_W-1:0] LETTER_BASE = 8'h57;   // 'a' minus ten
	localparam logic [CHAR_W-1:0] NULL_CHAR   = 8'h00;
	localparam logic [RADIX_W-1:0] NUM_DECIMAL_DIGITS = 6'd10;
	localparam logic [RADIX_W-1:0] NUM_SYMBOLS        = 6'd36;

	// output beat source select
	localparam logic [1:0] OSEL_SIGN  = 2'd0;
	localparam logic [1:0] OSEL_DIGIT = 2'd1;
	localparam logic [1:0] OSEL_ERROR = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic       load;       // capture a new item with a valid radix
		logic       div_run;    // advance the divider one step
		logic       rd_issue;   // read the digit store at the emit index
		logic       out_load;   // load the output register
		logic [1:0] out_sel;    // source of the loaded beat
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic radix_ok;     // radix on the input port lies in range
		logic neg;          // minus sign leads the run
		logic div_last;     // divider step in flight finishes a digit
		logic digit_stop;   // digit finishing now is the final one
		logic idx_zero;     // emit index points at the least significant digit
		logic out_free;     // output register can take a beat this cycle
	} dp_stat_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < NUM_DECIMAL_DIGITS) begin
			c = ZERO_CHAR + CHAR_W'(d);
		end else if (d < NUM_SYMBOLS) begin
			c = LETTER_BASE + CHAR_W'(d);
		end else begin
			c = ZERO_CHAR;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/itra_ctrl.sv */
// sequencing state machine for integer_to_radix_ascii
// depends on itra_pkg; drives itra_dp through ctrl_cmd_t and reads dp_stat_t
`timescale 1ns / 1ps
`default_nettype none

module itra_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire itra_pkg::dp_stat_t stat,
	output itra_pkg::ctrl_cmd_t     cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_SIGN = 3'd2;
	localparam logic [2:0] S_READ = 3'd3;
	localparam logic [2:0] S_SEND = 3'd4;
	localparam logic [2:0] S_ERR  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (stat.radix_ok) begin
						cmd.load = 1'b1;
						state_d  = S_DIV;
					end else begin
						state_d = S_ERR;
					end
				end
			end
			S_DIV: begin
				cmd.div_run = 1'b1;
				if (stat.div_last && stat.digit_stop) begin
					state_d = stat.neg ? S_SIGN : S_READ;
				end
			end
			S_SIGN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = itra_pkg::OSEL_SIGN;
					state_d      = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_SEND;
			end
			S_SEND: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = itra_pkg::OSEL_DIGIT;
					state_d      = stat.idx_zero ? S_IDLE : S_READ;
				end
			end
			S_ERR: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = itra_pkg::OSEL_ERROR;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// bad radix goes straight to the error beat
	a_err_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && !stat.radix_ok) |=> (state_q == S_ERR))
		else $error("bad radix did not lead to error beat");

	// never overwrite a beat the receiver has not taken
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("output register loaded while occupied");

	// a new item only enters from idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == S_IDLE && !in_stall))
		else $error("item loaded outside idle");

endmodule

`default_nettype wire

/* rtl/core/itra_dp.sv */
// datapath for integer_to_radix_ascii: digit divider, digit store, output register
// depends on itra_pkg; commanded by itra_ctrl
`timescale 1ns / 1ps
`default_nettype none

module itra_dp #(
	parameter int VALUE_WIDTH = itra_pkg::DEF_VALUE_WIDTH,
	parameter int MAX_DIGITS  = itra_pkg::DEF_MAX_DIGITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic signed [VALUE_WIDTH-1:0]       value,
	input  wire logic [itra_pkg::RADIX_IN_W-1:0]     radix,
	input  wire itra_pkg::ctrl_cmd_t                 cmd,
	output itra_pkg::dp_stat_t                       stat,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [itra_pkg::CHAR_W-1:0]              character,
	output logic                                     last,
	output logic                                     error
);

	localparam int DIV_STEPS = (VALUE_WIDTH + itra_pkg::DIV_BITS - 1) / itra_pkg::DIV_BITS;
	localparam int PAD_W     = DIV_STEPS * itra_pkg::DIV_BITS;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W     = $clog2(MAX_DIGITS);
	localparam int RW        = itra_pkg::RADIX_W;

	// working registers
	logic [PAD_W-1:0]  div_q;
	logic [RW-1:0]     rem_q;
	logic [RW-1:0]     radix_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	logic [RW-1:0]     rd_data_s1;

	// digit store, least significant digit at index zero
	logic [RW-1:0] digit_store_q [MAX_DIGITS];

	// output register
	logic                        out_valid_q;
	logic [itra_pkg::CHAR_W-1:0] char_q;
	logic                        last_q;
	logic                        error_q;

	logic [VALUE_WIDTH-1:0] val_u;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   neg_in;
	logic [PAD_W-1:0]       quot_next;
	logic [RW-1:0]          rem_next;
	logic [CNT_W-1:0]       count_next;
	logic [CNT_W-1:0]       limit;
	logic                   div_last;
	logic                   out_free;
	logic [itra_pkg::CHAR_W-1:0] char_d;
	logic                   last_d;
	logic                   error_d;

	assign val_u  = value;
	assign neg_in = (radix == itra_pkg::DECIMAL) && val_u[VALUE_WIDTH-1];
	assign mag    = neg_in ? (~val_u + 1'b1) : val_u;

	// DIV_BITS restoring steps on the narrow remainder
	always_comb begin
		logic [RW:0]      r;
		logic [PAD_W-1:0] d;
		r = {1'b0, rem_q};
		d = div_q;
		for (int b = 0; b < itra_pkg::DIV_BITS; b++) begin
			r = {r[RW-1:0], d[PAD_W-1]};
			d = {d[PAD_W-2:0], 1'b0};
			if (r >= {1'b0, radix_q}) begin
				r    = r - {1'b0, radix_q};
				d[0] = 1'b1;
			end
		end
		rem_next  = r[RW-1:0];
		quot_next = d;
	end

	assign div_last   = (step_q == STEP_W'(DIV_STEPS - 1));
	assign count_next = count_q + 1'b1;
	assign limit      = CNT_W'(MAX_DIGITS) - CNT_W'(neg_q);
	assign out_free   = !out_valid_q || !out_stall;

	always_comb begin
		stat            = '0;
		stat.radix_ok   = (radix >= itra_pkg::RADIX_MIN) && (radix <= itra_pkg::RADIX_MAX);
		stat.neg        = neg_q;
		stat.div_last   = div_last;
		stat.digit_stop = (quot_next == '0) || (count_next == limit);
		stat.idx_zero   = (idx_q == '0);
		stat.out_free   = out_free;
	end

	// beat source decode
	always_comb begin
		unique case (cmd.out_sel)
			itra_pkg::OSEL_SIGN: begin
				char_d  = itra_pkg::MINUS_CHAR;
				last_d  = 1'b0;
				error_d = 1'b0;
			end
			itra_pkg::OSEL_DIGIT: begin
				char_d  = itra_pkg::digit_char(rd_data_s1);
				last_d  = (idx_q == '0);
				error_d = 1'b0;
			end
			itra_pkg::OSEL_ERROR: begin
				char_d  = itra_pkg::NULL_CHAR;
				last_d  = 1'b1;
				error_d = 1'b1;
			end
			default: begin
				char_d  = itra_pkg::NULL_CHAR;
				last_d  = 1'b1;
				error_d = 1'b1;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q       <= 1'b0;
			step_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				neg_q   <= neg_in;
				step_q  <= '0;
				count_q <= '0;
			end else if (cmd.div_run) begin
				if (div_last) begin
					step_q  <= '0;
					count_q <= count_next;
					idx_q   <= count_q[IDX_W-1:0];
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			if (cmd.out_load && cmd.out_sel == itra_pkg::OSEL_DIGIT) begin
				idx_q <= idx_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_q   <= PAD_W'(mag);
			rem_q   <= '0;
			radix_q <= radix[RW-1:0];
		end else if (cmd.div_run) begin
			div_q <= quot_next;
			rem_q <= div_last ? '0 : rem_next;
		end
		if (cmd.out_load) begin
			char_q  <= char_d;
			last_q  <= last_d;
			error_q <= error_d;
		end
	end

	// digit store write and registered read
	always_ff @(posedge clk) begin
		if (cmd.div_run && div_last) begin
			digit_store_q[count_q[IDX_W-1:0]] <= rem_next;
		end
		if (cmd.rd_issue) begin
			rd_data_s1 <= digit_store_q[idx_q];
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;
	assign error     = error_q;

	// store never overfills
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_DIGITS))
		else $error("digit count beyond store depth");

	// a written digit is below the radix
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_run && div_last) |-> (rem_next < radix_q))
		else $error("digit not below radix");

	// a new item starts from an empty store and a fresh divider
	a_load_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (count_q == '0 && step_q == '0))
		else $error("load did not clear digit count");

endmodule

`default_nettype wire

/* rtl/core/integer_to_radix_ascii.sv */
// integer_to_radix_ascii: signed integer to ASCII text in radix 2 to 36
// depends on itra_pkg; instantiates itra_ctrl and itra_dp
//
// usage:
//  input channel (in_valid / in_stall) carries value and radix; one beat is one item
//  output channel (out_valid / out_stall) carries character, last and error; one item
//  gives a run of beats, most significant character first, last set on the final one
//  radix 10 with a negative value leads with '-'; other radixes read value as unsigned
//  a radix outside 2..36 gives a single beat: character 0, last 1, error 1
//  one item at a time: in_stall stays high from acceptance until the final beat of
//  the run is in the output register; the next item can enter while that beat waits
//  each digit comes from repeated steps of the shared divider, which retires four
//  quotient bits a cycle; each character is then sent as a store read followed by
//  an output load, and the sign as an output load alone
//  receiver stall: the finished beat holds in the output register and the sequencer
//  waits; no beat is lost or repeated
//  reset (arst_n low, asynchronous): sequencer idle, output empty; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_ascii #(
	parameter int VALUE_WIDTH = itra_pkg::DEF_VALUE_WIDTH,
	parameter int MAX_DIGITS  = itra_pkg::DEF_MAX_DIGITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic signed [VALUE_WIDTH-1:0]   value,
	input  wire logic [itra_pkg::RADIX_IN_W-1:0] radix,
	// output channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [itra_pkg::CHAR_W-1:0]          character,
	output logic                                 last,
	output logic                                 error
);

	// command and status between sequencer and datapath
	itra_pkg::ctrl_cmd_t cmd;
	itra_pkg::dp_stat_t  stat;

	// sequencer: idle, divide, sign, read, send, error beat
	itra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// divider, digit store and output register
	itra_dp #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.radix     (radix),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last),
		.error     (error)
	);

	// an error beat stands alone and carries a null character
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error) |-> (last && character == itra_pkg::NULL_CHAR))
		else $error("error beat malformed");

	// no new item is taken while a run is still being produced
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item accepted during a run");

endmodule

`default_nettype wire
